// File: rtl/core/edt_pkg.sv
// Shared types and constants for the event de-duplication table.
// Used by edt_cell, event_dedup_table_with_upgrade_top and the testbench; no dependencies.
package edt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int KEY_W    = 24;
    localparam int SRC_W    = 16;
    localparam int SEQ_W    = 8;
    localparam int CHAN_W   = 8;
    localparam int ENERGY_W = 8;
    localparam int TIME_W   = 32;
    localparam int WINDOW_W = 16;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd800;

    localparam logic [CHAN_W-1:0] CHAN_PREFERRED = 8'd0;
    localparam logic [CHAN_W-1:0] CHAN_SECONDARY = 8'd1;

    typedef enum logic [1:0] {
        VERDICT_DROP    = 2'd0,
        VERDICT_NEW     = 2'd1,
        VERDICT_UPGRADE = 2'd2
    } t_verdict;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [CHAN_W-1:0]   chan;
        logic [ENERGY_W-1:0] energy;
        logic [TIME_W-1:0]   now;
    } t_event;

    // Lookup token passed from cell to cell, one cell per cycle.
    typedef struct packed {
        logic     valid;
        logic     hit;
        t_verdict verdict;
        t_event   ev;
    } t_token;

endpackage

// File: rtl/core/edt_cell.sv
// One table entry of the de-duplication chain: holds the entry, checks the
// passing lookup token against it and updates in place. Depends on edt_pkg.
module edt_cell
    import edt_pkg::*;
#(
    parameter int IDX_W    = $clog2(TABLE_ENTRIES_DEF),
    parameter int CELL_IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [WINDOW_W-1:0] i_window,
    input  t_token              i_tok,
    output t_token              o_tok,
    input  logic                i_ins_en,
    input  logic [IDX_W-1:0]    i_ins_slot,
    input  t_event              i_ins_ev
);

    logic                r_valid;
    logic [KEY_W-1:0]    r_key;
    logic [CHAN_W-1:0]   r_chan;
    logic [ENERGY_W-1:0] r_energy;
    logic [TIME_W-1:0]   r_time;
    t_token              r_tok;

    logic                n_valid;
    logic [KEY_W-1:0]    n_key;
    logic [CHAN_W-1:0]   n_chan;
    logic [ENERGY_W-1:0] n_energy;
    logic [TIME_W-1:0]   n_time;
    t_token              n_tok;

    logic [TIME_W-1:0]   w_age;
    logic                w_match;
    logic                w_ins_here;

    assign w_age      = i_tok.ev.now - r_time;
    assign w_match    = i_tok.valid && !i_tok.hit && r_valid && (r_key == i_tok.ev.key);
    assign w_ins_here = i_ins_en && (i_ins_slot == IDX_W'(CELL_IDX));

    always_comb begin
        n_valid  = r_valid;
        n_key    = r_key;
        n_chan   = r_chan;
        n_energy = r_energy;
        n_time   = r_time;
        n_tok    = i_tok;
        priority if (w_ins_here) begin
            n_valid  = 1'b1;
            n_key    = i_ins_ev.key;
            n_chan   = i_ins_ev.chan;
            n_energy = i_ins_ev.energy;
            n_time   = i_ins_ev.now;
        end else if (w_match) begin
            n_tok.hit = 1'b1;
            priority if (w_age >= {{(TIME_W-WINDOW_W){1'b0}}, i_window}) begin
                // stale entry: treat as a fresh event
                n_chan        = i_tok.ev.chan;
                n_energy      = i_tok.ev.energy;
                n_time        = i_tok.ev.now;
                n_tok.verdict = VERDICT_NEW;
            end else if (r_chan == CHAN_PREFERRED && i_tok.ev.chan == CHAN_SECONDARY) begin
                n_tok.verdict = VERDICT_DROP;
            end else if (r_chan == CHAN_SECONDARY && i_tok.ev.chan == CHAN_PREFERRED) begin
                // preferred path wins even at lower energy
                n_chan        = CHAN_PREFERRED;
                n_energy      = i_tok.ev.energy;
                n_time        = i_tok.ev.now;
                n_tok.verdict = VERDICT_UPGRADE;
            end else if (i_tok.ev.energy > r_energy) begin
                n_energy      = i_tok.ev.energy;
                n_time        = i_tok.ev.now;
                n_tok.verdict = VERDICT_UPGRADE;
            end else begin
                n_tok.verdict = VERDICT_DROP;
            end
        end else begin
            n_tok = i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_chan   <= n_chan;
        r_energy <= n_energy;
        r_time   <= n_time;
    end

    assign o_tok = r_tok;

endmodule

// File: rtl/core/event_dedup_table_with_upgrade_top.sv
// Event de-duplication table with upgrade: lookup token walks a chain of
// TABLE_ENTRIES cells, one cell per cycle, first matching cell decides.
// The start transfer is registered in the inject register, passes each cell's token register in
// turn, and the end-of-chain result is registered into the strobe and verdict outputs.
// One event at a time: busy blocks a new start until the walk through the cell chain ends.
// Reset: all entries invalid at once, window 800 ms, insert slot 0.
module event_dedup_table_with_upgrade_top
    import edt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [SRC_W-1:0]    i_source_id,
    input  logic [SEQ_W-1:0]    i_shot_sequence,
    input  logic [CHAN_W-1:0]   i_path_channel,
    input  logic [ENERGY_W-1:0] i_strength,
    input  logic [TIME_W-1:0]   i_now_ms,
    output logic                o_strobe,
    output logic [1:0]          o_verdict,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [WINDOW_W-1:0] i_cfg_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

    logic                r_busy;
    logic [WINDOW_W-1:0] r_window;
    logic [IDX_W-1:0]    r_ptr;
    t_token              r_inj;
    logic                r_ins_en;
    t_event              r_ins_ev;
    logic                r_strobe;
    t_verdict            r_verdict;

    t_token              w_tok [TABLE_ENTRIES+1];
    t_token              w_end;
    logic                w_accept;

    assign w_accept = start && !r_busy;
    assign w_tok[0] = r_inj;
    assign w_end    = w_tok[TABLE_ENTRIES];

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        edt_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_window   (r_window),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1]),
            .i_ins_en   (r_ins_en),
            .i_ins_slot (r_ptr),
            .i_ins_ev   (r_ins_ev)
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_window  <= WINDOW_RESET;
            r_ptr     <= '0;
            r_inj     <= '0;
            r_ins_en  <= 1'b0;
            r_strobe  <= 1'b0;
            r_verdict <= VERDICT_DROP;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_window <= i_cfg_data;
            end
            r_inj.valid <= w_accept;
            if (w_accept) begin
                r_busy        <= 1'b1;
                r_inj.hit     <= 1'b0;
                r_inj.verdict <= VERDICT_NEW;
                r_inj.ev      <= '{key:    {i_source_id, i_shot_sequence},
                                   chan:   i_path_channel,
                                   energy: i_strength,
                                   now:    i_now_ms};
            end
            // insert slot advances once the miss write has landed
            if (r_ins_en) begin
                r_ptr <= (r_ptr == LAST_SLOT) ? '0 : r_ptr + IDX_W'(1);
            end
            r_ins_en <= w_end.valid && !w_end.hit;
            r_strobe <= w_end.valid;
            if (w_end.valid) begin
                r_busy    <= 1'b0;
                r_verdict <= w_end.hit ? w_end.verdict : VERDICT_NEW;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_end.valid) begin
            r_ins_ev <= w_end.ev;
        end
    end

    assign busy        = r_busy;
    // no window write in the same cycle as an event transfer
    assign o_cfg_ready = !r_busy && !start;
    assign o_strobe    = r_strobe;
    assign o_verdict   = r_verdict;

    // the token only travels while an event is in flight
    a_end_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end.valid |-> r_busy)
        else $error("lookup token left the chain while idle");

    // a miss insert always goes with a new-event verdict
    a_insert_is_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ins_en |-> (o_strobe && o_verdict == VERDICT_NEW))
        else $error("insert without new-event verdict");

    // accepted event enters the chain on the next cycle
    a_accept_injects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_busy && r_inj.valid))
        else $error("accepted event not injected");

    // result strobe only after the walk finished
    a_strobe_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (!r_busy && $past(w_end.valid)))
        else $error("strobe without completed lookup");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for event_dedup_table_with_upgrade_top: directed and random events,
// with verdicts predicted from a local copy of the table. Depends on edt_pkg and the top RTL.
module testbench;
    import edt_pkg::*;

    localparam int TABLE_DEPTH = TABLE_ENTRIES_DEF;

    typedef struct {
        logic [SRC_W-1:0]    src;
        logic [SEQ_W-1:0]    seq;
        logic [CHAN_W-1:0]   chan;
        logic [ENERGY_W-1:0] strength;
        logic [TIME_W-1:0]   now;
    } t_shot;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [SRC_W-1:0]    i_source_id = '0;
    logic [SEQ_W-1:0]    i_shot_sequence = '0;
    logic [CHAN_W-1:0]   i_path_channel = '0;
    logic [ENERGY_W-1:0] i_strength = '0;
    logic [TIME_W-1:0]   i_now_ms = '0;
    logic                o_strobe;
    logic [1:0]          o_verdict;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [WINDOW_W-1:0] i_cfg_data = '0;

    // pending events and verdicts still owed by the block
    t_shot    shot_q[$];
    t_verdict verdict_q[$];
    t_shot    drv_shot;
    logic     calm = 1'b0;

    // local copy of the dedup table
    logic                tbl_valid[TABLE_DEPTH];
    logic [KEY_W-1:0]    tbl_key[TABLE_DEPTH];
    logic [CHAN_W-1:0]   tbl_chan[TABLE_DEPTH];
    logic [ENERGY_W-1:0] tbl_energy[TABLE_DEPTH];
    logic [TIME_W-1:0]   tbl_stamp[TABLE_DEPTH];
    int                  ins_ptr;
    logic [WINDOW_W-1:0] window_ms;

    int errors = 0;
    int n_new = 0;
    int n_upgrade = 0;
    int n_drop = 0;
    int n_windows = 0;
    logic [TIME_W-1:0] clock_ms;

    event_dedup_table_with_upgrade_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_source_id     (i_source_id),
        .i_shot_sequence (i_shot_sequence),
        .i_path_channel  (i_path_channel),
        .i_strength      (i_strength),
        .i_now_ms        (i_now_ms),
        .o_strobe        (o_strobe),
        .o_verdict       (o_verdict),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Decides one event against the table and updates it.
    function automatic t_verdict judge_shot(input t_shot s);
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] age;
        t_verdict          v;
        int                slot;
        key  = {s.src, s.seq};
        v    = VERDICT_NEW;
        slot = -1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot < 0 && tbl_valid[i] && tbl_key[i] == key) slot = i;
        end
        if (slot < 0) begin
            slot    = ins_ptr;
            ins_ptr = (ins_ptr + 1) % TABLE_DEPTH;
        end else begin
            age = s.now - tbl_stamp[slot];
            if (age >= TIME_W'(window_ms)) begin
                v = VERDICT_NEW;
            end else if (tbl_chan[slot] == CHAN_PREFERRED && s.chan == CHAN_SECONDARY) begin
                return VERDICT_DROP;
            end else if (tbl_chan[slot] == CHAN_SECONDARY && s.chan == CHAN_PREFERRED) begin
                tbl_chan[slot]   = CHAN_PREFERRED;
                tbl_energy[slot] = s.strength;
                tbl_stamp[slot]  = s.now;
                return VERDICT_UPGRADE;
            end else if (s.strength > tbl_energy[slot]) begin
                // stored channel is kept
                tbl_energy[slot] = s.strength;
                tbl_stamp[slot]  = s.now;
                return VERDICT_UPGRADE;
            end else begin
                return VERDICT_DROP;
            end
        end
        tbl_valid[slot]  = 1'b1;
        tbl_key[slot]    = key;
        tbl_chan[slot]   = s.chan;
        tbl_energy[slot] = s.strength;
        tbl_stamp[slot]  = s.now;
        return v;
    endfunction

    // driver: holds start until the transfer, then moves on
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (shot_q.size() != 0 && (calm || $urandom_range(0, 99) >= 7)) begin
                drv_shot = shot_q.pop_front();
                start           <= 1'b1;
                i_source_id     <= drv_shot.src;
                i_shot_sequence <= drv_shot.seq;
                i_path_channel  <= drv_shot.chan;
                i_strength      <= drv_shot.strength;
                i_now_ms        <= drv_shot.now;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: tracks config and event transfers, checks each verdict strobe
    always @(posedge i_clk) begin
        t_shot    s;
        t_verdict exp_v;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
            ins_ptr   = 0;
            window_ms = WINDOW_RESET;
            verdict_q.delete();
        end else begin
            if (o_strobe) begin
                if (verdict_q.size() == 0) begin
                    $error("verdict: expected none, actual %0d", o_verdict);
                    errors++;
                end else begin
                    exp_v = verdict_q.pop_front();
                    case (exp_v)
                        VERDICT_NEW:     n_new++;
                        VERDICT_UPGRADE: n_upgrade++;
                        default:         n_drop++;
                    endcase
                    if (o_verdict !== exp_v) begin
                        $error("verdict: expected %0d, actual %0d", exp_v, o_verdict);
                        errors++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) window_ms = i_cfg_data;
            if (start && !busy) begin
                s.src      = i_source_id;
                s.seq      = i_shot_sequence;
                s.chan     = i_path_channel;
                s.strength = i_strength;
                s.now      = i_now_ms;
                verdict_q.push_back(judge_shot(s));
            end
        end
    end

    task automatic add_shot(input logic [SRC_W-1:0] src, input logic [SEQ_W-1:0] seq,
                            input logic [CHAN_W-1:0] chan, input logic [ENERGY_W-1:0] strength,
                            input logic [TIME_W-1:0] now);
        t_shot s;
        s.src      = src;
        s.seq      = seq;
        s.chan     = chan;
        s.strength = strength;
        s.now      = now;
        shot_q.push_back(s);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (shot_q.size() != 0 || start || verdict_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [WINDOW_W-1:0] w);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= w;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_windows++;
    endtask

    // Events drawn mostly from a small key pool so that hits, upgrades and
    // evictions all occur; one in ten is unrelated noise.
    task automatic run_random(input int n, input int pool, input int max_step);
        logic [SRC_W-1:0]  base_src;
        logic [SEQ_W-1:0]  base_seq;
        logic [CHAN_W-1:0] chan;
        int                k;
        int                r;
        base_src = SRC_W'($urandom);
        base_seq = SEQ_W'($urandom);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 10) begin
                add_shot(SRC_W'($urandom), SEQ_W'($urandom), CHAN_W'($urandom),
                         ENERGY_W'($urandom), $urandom);
            end else begin
                k = $urandom_range(0, pool - 1);
                r = $urandom_range(0, 19);
                if (r < 9) chan = CHAN_PREFERRED;
                else if (r < 18) chan = CHAN_SECONDARY;
                else chan = CHAN_W'($urandom_range(0, 255));
                clock_ms += $urandom_range(0, max_step);
                add_shot(base_src ^ SRC_W'(k * 37), base_seq + SEQ_W'(k), chan,
                         ENERGY_W'($urandom), clock_ms);
            end
        end
        wait_drained();
    endtask

    initial begin
        logic [WINDOW_W-1:0] w;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset window of 800 ms
        add_shot(16'h0000, 8'h00, 8'd0, 8'd0, 32'd1000);     // zero key on an empty table
        add_shot(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 32'd1000);
        add_shot(16'h0000, 8'h00, 8'd0, 8'd0, 32'd1000);     // same strength: dropped
        add_shot(16'h5A5A, 8'hA5, 8'd1, 8'd50, 32'd2000);
        add_shot(16'h5A5A, 8'hA5, 8'd1, 8'd40, 32'd2010);    // weaker
        add_shot(16'h5A5A, 8'hA5, 8'd1, 8'd60, 32'd2020);    // stronger
        add_shot(16'h5A5A, 8'hA5, 8'd0, 8'd10, 32'd2030);    // moves to channel 0, weaker
        add_shot(16'h5A5A, 8'hA5, 8'd1, 8'd255, 32'd2040);   // channel 1 never beats 0
        add_shot(16'h5A5A, 8'hA5, 8'd7, 8'd255, 32'd2050);   // odd channel, strength only
        add_shot(16'h5A5A, 8'hA5, 8'd0, 8'd255, 32'd2849);   // one ms inside the window
        add_shot(16'h5A5A, 8'hA5, 8'd1, 8'd3, 32'd2850);     // exactly at the window
        add_shot(16'h5A5A, 8'hA5, 8'd200, 8'd4, 32'd2860);
        add_shot(16'h5A5A, 8'hA5, 8'd0, 8'd0, 32'd2870);
        add_shot(16'h0001, 8'h00, 8'd1, 8'd100, 32'hFFFF_FFF0);
        add_shot(16'h0001, 8'h00, 8'd1, 8'd101, 32'h0000_0010); // age across time wrap
        add_shot(16'h0001, 8'h00, 8'd1, 8'd101, 32'h0000_0330);
        add_shot(16'hFFFF, 8'hFE, 8'd1, 8'd128, 32'd0);
        write_window(16'd0);
        add_shot(16'h5A5A, 8'hA5, 8'd0, 8'd255, 32'd3000);   // every hit is fresh
        add_shot(16'h5A5A, 8'hA5, 8'd1, 8'd0, 32'd3000);
        add_shot(16'h8000, 8'h80, 8'd1, 8'd1, 32'h8000_0000);

        clock_ms = 32'd5000;
        run_random(150, 20, 50);
        write_window(16'hFFFF);
        clock_ms = 32'hFFFF_0000;
        run_random(400, 40, 2000);
        w = WINDOW_W'($urandom);
        write_window(w);
        run_random(400, 80, int'(w) / 16 + 1);
        write_window(16'd1);
        run_random(200, 30, 2);
        write_window(16'd800);
        calm = 1'b1;
        run_random(400, 30, 60);
        calm = 1'b0;
        w = WINDOW_W'($urandom_range(1, 4000));
        write_window(w);
        run_random(350, 50, int'(w) / 20 + 1);

        repeat (TABLE_DEPTH + 20) @(posedge i_clk);
        if (verdict_q.size() != 0) begin
            $error("verdict: expected %0d more, actual none", verdict_q.size());
            errors++;
        end
        $display("Checked %0d verdicts (%0d new, %0d upgrades, %0d dropped) over %0d windows.",
                 n_new + n_upgrade + n_drop, n_new, n_upgrade, n_drop, n_windows + 1);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
